// ===== design/ntao_pkg.sv =====
package ntao_pkg;

   // Width of the time value field on the request channel.
   localparam int VALUE_BITS = 16;

   // Operation codes carried by a request transaction.
   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SET_TIME  = 2'd1,
      OP_SET_ALARM = 2'd2,
      OP_READ      = 2'd3
   } op_type;

endpackage

// ===== design/ntao_core.sv =====
module ntao_core #(
   parameter int COUNTER_BITS = 24,
   parameter int NET_BITS     = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  ntao_pkg::op_type                    op,
   input  logic [ntao_pkg::VALUE_BITS-1:0]     value,
   output logic [NET_BITS-1:0]                 network_time,
   output logic                                accepted,
   output logic                                alarm,
   output logic                                armed,
   output logic [COUNTER_BITS-1:0]             compare_value
);

   localparam int HI_BITS = COUNTER_BITS - NET_BITS;
   localparam logic [HI_BITS-1:0] HI_ONE = 1;
   localparam logic [COUNTER_BITS-1:0] CNT_ONE = 1;

   logic [COUNTER_BITS-1:0] counter_ff, counter_in;
   logic [NET_BITS-1:0]     offset_ff, offset_in;
   logic [NET_BITS-1:0]     target_ff, target_in;
   logic [COUNTER_BITS-1:0] compare_ff, compare_in;
   logic                    enable_ff, enable_in;

   logic [COUNTER_BITS-1:0] counter_inc;
   logic                    value_too_big;
   logic [NET_BITS-1:0]     new_offset;
   logic [NET_BITS-1:0]     form_offset;
   logic [NET_BITS-1:0]     form_target;
   logic [NET_BITS-1:0]     form_low;
   logic [COUNTER_BITS-1:0] form_raw;
   logic [COUNTER_BITS-1:0] form_cmp;

   assign counter_inc   = counter_ff + CNT_ONE;
   assign value_too_big = |value[ntao_pkg::VALUE_BITS-1:NET_BITS];
   assign new_offset    = value[NET_BITS-1:0] - counter_ff[NET_BITS-1:0];

   // One compare former serves both set operations.
   assign form_offset = (op == ntao_pkg::OP_SET_TIME) ? new_offset : offset_ff;
   assign form_target = (op == ntao_pkg::OP_SET_ALARM) ? value[NET_BITS-1:0] : target_ff;
   assign form_low    = form_target - form_offset;
   assign form_raw    = {counter_ff[COUNTER_BITS-1:NET_BITS], form_low};
   assign form_cmp    = (form_raw <= counter_ff) ?
                        {counter_ff[COUNTER_BITS-1:NET_BITS] + HI_ONE, form_low} : form_raw;

   always_comb begin
      counter_in = counter_ff;
      offset_in  = offset_ff;
      target_in  = target_ff;
      compare_in = compare_ff;
      enable_in  = enable_ff;
      accepted   = 1'b1;
      alarm      = 1'b0;
      case (op)
         ntao_pkg::OP_TICK: begin
            counter_in = counter_inc;
            if (enable_ff && (counter_inc == compare_ff)) begin
               alarm     = 1'b1;
               enable_in = 1'b0;
            end
         end
         ntao_pkg::OP_SET_TIME: begin
            if (value_too_big) begin
               accepted = 1'b0;
            end else begin
               offset_in = new_offset;
               if (enable_ff) begin
                  compare_in = form_cmp;
               end
            end
         end
         ntao_pkg::OP_SET_ALARM: begin
            target_in  = value[NET_BITS-1:0];
            compare_in = form_cmp;
            enable_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign network_time  = counter_in[NET_BITS-1:0] + offset_in;
   assign armed         = enable_in;
   assign compare_value = compare_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         offset_ff  <= '0;
         target_ff  <= '0;
         compare_ff <= '0;
         enable_ff  <= 1'b0;
      end else if (step) begin
         counter_ff <= counter_in;
         offset_ff  <= offset_in;
         target_ff  <= target_in;
         compare_ff <= compare_in;
         enable_ff  <= enable_in;
      end
   end

endmodule

// ===== design/network_time_alarm_offset.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_op, req_time_value
// rsp_      out        rsp_valid/rsp_stall  rsp_network_time, rsp_accepted, rsp_alarm,
//                                           rsp_armed, rsp_compare_value
//
// One transaction is taken every clock cycle while no stall holds the flow; each
// response passes through the input register, the core state update and the output register.
// The rate is set by the state update in the core, which reads and
// writes the counter, offset, target and compare registers once per transaction.
// Reset is synchronous and active high; it clears the clock state and both stages.
// A stall on the response side holds the output register and then the input register.

module network_time_alarm_offset #(
   parameter int COUNTER_BITS = 24,
   parameter int NET_BITS     = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [ntao_pkg::VALUE_BITS-1:0]  req_time_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [NET_BITS-1:0]              rsp_network_time,
   output logic                             rsp_accepted,
   output logic                             rsp_alarm,
   output logic                             rsp_armed,
   output logic [COUNTER_BITS-1:0]          rsp_compare_value
);

   // Input register. It holds one request transaction until the core can take it.
   logic                            in_valid_ff, in_valid_in;
   ntao_pkg::op_type                in_op_ff;
   logic [ntao_pkg::VALUE_BITS-1:0] in_value_ff;

   // Output register. It holds one response transaction until the far side takes it.
   logic                            out_valid_ff, out_valid_in;
   logic [NET_BITS-1:0]             out_time_ff;
   logic                            out_accepted_ff;
   logic                            out_alarm_ff;
   logic                            out_armed_ff;
   logic [COUNTER_BITS-1:0]         out_compare_ff;

   logic                            take;
   logic                            advance;

   logic [NET_BITS-1:0]             core_time;
   logic                            core_accepted;
   logic                            core_alarm;
   logic                            core_armed;
   logic [COUNTER_BITS-1:0]         core_compare;

   // The held request moves on whenever the output register is free or is being
   // emptied in this cycle, so back-to-back transactions flow without a bubble.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ntao_core #(
      .COUNTER_BITS (COUNTER_BITS),
      .NET_BITS     (NET_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .op            (in_op_ff),
      .value         (in_value_ff),
      .network_time  (core_time),
      .accepted      (core_accepted),
      .alarm         (core_alarm),
      .armed         (core_armed),
      .compare_value (core_compare)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset; they are qualified by the valid flags.
   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff    <= ntao_pkg::op_type'(req_op);
         in_value_ff <= req_time_value;
      end
      if (advance) begin
         out_time_ff     <= core_time;
         out_accepted_ff <= core_accepted;
         out_alarm_ff    <= core_alarm;
         out_armed_ff    <= core_armed;
         out_compare_ff  <= core_compare;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_network_time  = out_time_ff;
   assign rsp_accepted      = out_accepted_ff;
   assign rsp_alarm         = out_alarm_ff;
   assign rsp_armed         = out_armed_ff;
   assign rsp_compare_value = out_compare_ff;

   // An alarm always disarms, so a response never shows both.
   a_alarm_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alarm) |-> !rsp_armed)
      else $error("alarm response still armed");

   // A rejected set-time transaction cannot also be an alarm.
   a_reject_no_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> !rsp_alarm)
      else $error("rejected transaction raised alarm");

   // The request side stalls only while a transaction is held in the input register.
   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   // A transaction that moves into the core shows up as a response in the next cycle.
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced transaction did not reach the output register");

endmodule
